>>> src/mtoa_pkg.sv
// shared types and constants for the multi-target overspeed alarm
// no dependencies; used by every module of the block
`default_nettype none

package mtoa_pkg;

  localparam int unsigned NumTargets = 3;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned ThreshW    = 15;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 15;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_MULTI     = 2'd2
  } cfg_reg_t;

  // per-target debounce phase
  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_PENDING = 2'd1,
    PH_ON      = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_one;
    logic signed [SpeedW-1:0] speed_two;
    logic signed [SpeedW-1:0] speed_three;
  } in_word_t;

  typedef struct packed {
    logic [2:0] alarm_bits;
    logic [2:0] alarm_code;
  } out_word_t;

  // alarm flags of all lanes for the current word
  typedef struct packed {
    logic [NumTargets-1:0] on;
  } lane_status_t;

  // bitmap to report code: pairs are numbered from the top down
  function automatic logic [2:0] code_of_bits(input logic [2:0] bits);
    logic [2:0] code;
    unique case (bits)
      3'b000:  code = 3'd0;
      3'b001:  code = 3'd1;
      3'b010:  code = 3'd2;
      3'b011:  code = 3'd6;
      3'b100:  code = 3'd3;
      3'b101:  code = 3'd5;
      3'b110:  code = 3'd4;
      default: code = 3'd7;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> src/mtoa_lane.sv
// one target lane: overspeed compare, debounce phase and run counter
// depends on mtoa_pkg
`default_nettype none

module mtoa_lane (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                update,
  input  wire logic signed [mtoa_pkg::SpeedW-1:0]  speed,
  input  wire logic        [mtoa_pkg::ThreshW-1:0] overspeed_limit,
  input  wire logic        [mtoa_pkg::CountW-1:0]  debounce_periods,
  output logic                                     on_next
);

  mtoa_pkg::phase_t                phase, phase_next;
  logic [mtoa_pkg::CountW-1:0]     run_count, run_count_next;
  logic [mtoa_pkg::CountW-1:0]     count_inc;
  logic signed [mtoa_pkg::SpeedW:0] neg_thresh;
  logic                            over;

  assign neg_thresh = -$signed({2'b00, overspeed_limit});
  assign over       = $signed({speed[mtoa_pkg::SpeedW-1], speed}) < neg_thresh;
  // saturate at all ones
  assign count_inc  = (&run_count) ? run_count : run_count + 1'b1;

  // next phase
  always_comb begin
    if (!over) begin
      phase_next = mtoa_pkg::PH_OFF;
    end else begin
      unique case (phase)
        mtoa_pkg::PH_PENDING:
          phase_next = (count_inc >= debounce_periods) ? mtoa_pkg::PH_ON
                                                       : mtoa_pkg::PH_PENDING;
        mtoa_pkg::PH_ON: phase_next = mtoa_pkg::PH_ON;
        default:         phase_next = mtoa_pkg::PH_PENDING;
      endcase
    end
  end

  // counter and flag
  always_comb begin
    if (!over) begin
      run_count_next = '0;
    end else begin
      unique case (phase)
        mtoa_pkg::PH_PENDING: run_count_next = count_inc;
        mtoa_pkg::PH_ON:      run_count_next = debounce_periods;
        default:              run_count_next = mtoa_pkg::CountW'(1);
      endcase
    end
    on_next = (phase_next == mtoa_pkg::PH_ON);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mtoa_pkg::PH_OFF;
      run_count <= '0;
    end else if (update) begin
      phase     <= phase_next;
      run_count <= run_count_next;
    end
  end

endmodule

`default_nettype wire

>>> src/mtoa_merge.sv
// merge stage: combines lane flags into bitmap and report code
// depends on mtoa_pkg
`default_nettype none

module mtoa_merge (
  input  wire mtoa_pkg::lane_status_t status,
  input  wire logic                   multi_target,
  output mtoa_pkg::out_word_t         result
);

  logic [2:0] bits;

  always_comb begin
    if (multi_target) begin
      bits = status.on;
      result.alarm_code = mtoa_pkg::code_of_bits(bits);
    end else begin
      bits = {2'b00, status.on[0]};
      result.alarm_code = {2'b00, status.on[0]};
    end
    result.alarm_bits = bits;
  end

endmodule

`default_nettype wire

>>> src/multi_target_overspeed_alarm_core.sv
// top level of the multi-target overspeed alarm
// depends on mtoa_pkg, mtoa_lane and mtoa_merge
`default_nettype none

// usage
//   input channel in_valid/in_ready/in_data: one word per sampling period,
//   carrying three signed speeds in 1/16 cm/s
//   output channel out_valid/out_ready/out_data: one word per input word,
//   alarm bitmap plus report code (0 means nothing to send)
//   config port cfg_we/cfg_index/cfg_data: 0 threshold, 1 debounce periods,
//   2 multi-target enable; other indexes are dropped; write only when idle
// result path: an accepted word's result is registered into out_data, or into the skid entry while the receiver stalls
// throughput: one word per clock while in_ready is high; the lanes update in parallel (targets 2 and 3
//   only in multi-target mode) and the merge feeds a two-entry output buffer
// stall: while the receiver holds off, one more word is taken into the skid
//   entry, then in_ready drops until the skid word moves up to the output
//   register; in_ready returns the cycle after that move
// reset: all targets go to off with zero counts, registers return to
//   threshold 1760, debounce 3, single-target mode; in_ready is low during rst

module multi_target_overspeed_alarm_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire mtoa_pkg::in_word_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output mtoa_pkg::out_word_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mtoa_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [mtoa_pkg::CfgDataW-1:0]      cfg_data
);

  // configuration registers
  logic [mtoa_pkg::ThreshW-1:0] overspeed_limit;
  logic [mtoa_pkg::CountW-1:0]  debounce_periods;
  logic                         multi_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      overspeed_limit  <= mtoa_pkg::ThreshW'(1760);
      debounce_periods <= mtoa_pkg::CountW'(3);
      multi_target     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtoa_pkg::REG_THRESHOLD: overspeed_limit  <= cfg_data[mtoa_pkg::ThreshW-1:0];
        mtoa_pkg::REG_DEBOUNCE:  debounce_periods <= cfg_data[mtoa_pkg::CountW-1:0];
        mtoa_pkg::REG_MULTI:     multi_target     <= cfg_data[0];
        default:                 ;  // unmapped index, dropped
      endcase
    end
  end

  // handshake
  logic                  skid_valid;
  mtoa_pkg::out_word_t   skid_data;
  logic                  accept;

  assign in_ready = !skid_valid && !rst;
  assign accept   = in_valid && in_ready;

  // lanes: target 1 updates on every accepted word, targets 2 and 3 only in multi mode
  logic signed [mtoa_pkg::SpeedW-1:0] speeds [mtoa_pkg::NumTargets];
  mtoa_pkg::lane_status_t             status;

  assign speeds[0] = in_data.speed_one;
  assign speeds[1] = in_data.speed_two;
  assign speeds[2] = in_data.speed_three;

  for (genvar g = 0; g < mtoa_pkg::NumTargets; g++) begin : g_lane
    mtoa_lane u_lane (
      .clk              (clk),
      .rst              (rst),
      .update           (accept && ((g == 0) || multi_target)),
      .speed            (speeds[g]),
      .overspeed_limit  (overspeed_limit),
      .debounce_periods (debounce_periods),
      .on_next          (status.on[g])
    );
  end

  // merge of lane flags into the result word
  mtoa_pkg::out_word_t result;

  mtoa_merge u_merge (
    .status       (status),
    .multi_target (multi_target),
    .result       (result)
  );

  // two-entry output buffer: main register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !out_ready) begin
        // receiver stalled: park a new word in the skid entry
        if (accept) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        // main register drains, skid moves up
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (accept) begin
        skid_data <= result;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (accept) begin
      out_data <= result;
    end
  end

  // checks
  skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  accept_gives_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word did not reach the output buffer");

  code_matches_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.alarm_bits == 3'd0) == (out_data.alarm_code == 3'd0)))
    else $error("report code disagrees with the alarm bitmap");

  skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> !skid_valid)
    else $error("skid entry failed to drain");

endmodule

`default_nettype wire
